// ===== hdl/bba_pkg.sv =====
// Package with the shared constants, codes and types of the buddy block allocator.
`default_nettype none

package bba_pkg;

    // Default sizes of the pool.
    localparam int DEF_MAX_UNITS = 1024;
    localparam int DEF_MAX_LOG   = 10;

    // Fixed field widths.
    localparam int UB_W      = 13;
    localparam int CNT_W     = 11;
    localparam int REQ_W     = 23;
    localparam int CFG_W     = 13;
    localparam int SHIFT_W   = REQ_W + 1;
    localparam int TAG_W     = 7;
    localparam int TAG_LOG_W = 5;

    // Tag layout: free-head flag, in-use flag, log2 size.
    localparam int TAG_FREE_BIT  = 6;
    localparam int TAG_INUSE_BIT = 5;

    // Register reset values and the smallest usable unit size.
    localparam logic [UB_W-1:0]  UNIT_BYTES_RST = 13'd8;
    localparam logic [UB_W-1:0]  UNIT_BYTES_MIN = 13'd8;
    localparam logic [CNT_W-1:0] UNIT_COUNT_RST = 11'd1024;

    // Configuration register indexes.
    localparam logic [0:0] CFG_UNIT_BYTES = 1'b0;
    localparam logic [0:0] CFG_UNIT_COUNT = 1'b1;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_ZERO_SIZE = 2'd2,
        STAT_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_CARVE,
        ST_IDLE,
        ST_A_SIZE,
        ST_A_SEARCH,
        ST_A_NEXT,
        ST_A_SPLIT,
        ST_A_MARK,
        ST_PUSH_A,
        ST_PUSH_B,
        ST_F_TAG,
        ST_F_BUDDY,
        ST_F_BTAG,
        ST_DONE
    } state_t;

    // Where a free-list push returns to.
    typedef enum logic [1:0] {
        RET_CARVE,
        RET_SPLIT,
        RET_FREE
    } ret_t;

    // Tag of a free block head of the given level.
    function automatic logic [TAG_W-1:0] tag_free(input logic [TAG_LOG_W-1:0] lg);
        return {1'b1, 1'b0, lg};
    endfunction

    // Tag of an allocated block head of the given level.
    function automatic logic [TAG_W-1:0] tag_inuse(input logic [TAG_LOG_W-1:0] lg);
        return {1'b0, 1'b1, lg};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/buddy_block_allocator_core.sv =====
// Top level of the buddy block allocator: sequencer, free-list heads and tag/link memories.
//
// Usage: each input beat on the s_ channel is one allocate (operation 0, request_bytes)
// or one free (operation 1, block_offset). Each input beat yields exactly one result
// beat on the m_ channel with status, granted_offset and granted_log.
// The block works on one item at a time; s_ready is high only while the sequencer idles.
// An allocate runs the size steps, then the level search steps, unlinks the head block,
// splits down with a free-list push per split, and marks the block in use. A free checks
// the tag, merges with the free buddy level by level, then pushes the merged block. The tag
// and link memories have a single registered read port each.
// After reset, and after every configuration write, a clearing pass walks all MAX_UNITS
// tag entries and then carves the pool into free blocks; s_ready stays low meanwhile.
// Results sit in an output register; a new item can be accepted while a result waits,
// and the block holds its next result until the receiver takes the waiting one.
// Configuration writes take effect at once and must be issued only while idle.
`default_nettype none

module buddy_block_allocator_core import bba_pkg::*; #(
    parameter int MAX_UNITS = DEF_MAX_UNITS,
    parameter int MAX_LOG   = DEF_MAX_LOG
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_operation,
    input  wire logic [REQ_W-1:0]              s_request_bytes,
    input  wire logic [$clog2(MAX_UNITS)-1:0]  s_block_offset,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [1:0]                    m_status,
    output logic      [$clog2(MAX_UNITS)-1:0]  m_granted_offset,
    output logic      [$clog2(MAX_LOG+1)-1:0]  m_granted_log,
    input  wire logic                          cfg_wr_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_wdata
);

    localparam int OFF_W = $clog2(MAX_UNITS);
    localparam int PTR_W = OFF_W + 1;
    localparam int LOG_W = $clog2(MAX_LOG + 1);
    localparam int CL_W  = $clog2(MAX_LOG + 2);
    localparam int UC_W  = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam logic [PTR_W-1:0] NIL      = PTR_W'(MAX_UNITS);
    localparam logic [UC_W-1:0]  UC_MAX   = UC_W'(MAX_UNITS);
    localparam logic [LOG_W-1:0] LOG_TOP  = LOG_W'(MAX_LOG);
    localparam logic [OFF_W-1:0] CLR_LAST = OFF_W'(MAX_UNITS - 1);

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    ret_t               ret_reg, ret_next;
    logic [UB_W-1:0]    ubytes_reg, ubytes_next;
    logic [CNT_W-1:0]   ucount_reg, ucount_next;
    logic [REQ_W-1:0]   req_reg, req_next;
    logic [SHIFT_W-1:0] cur_reg, cur_next;
    logic [LOG_W-1:0]   i_reg, i_next;
    logic [LOG_W-1:0]   j_reg, j_next;
    logic [LOG_W-1:0]   lg_reg, lg_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [OFF_W-1:0]   buddy_reg, buddy_next;
    logic [OFF_W-1:0]   push_off_reg, push_off_next;
    logic [LOG_W-1:0]   push_lg_reg, push_lg_next;
    logic [PTR_W-1:0]   h_reg, h_next;
    logic [OFF_W-1:0]   clr_reg, clr_next;
    logic [UC_W:0]      carve_off_reg, carve_off_next;
    logic [CL_W-1:0]    carve_cnt_reg, carve_cnt_next;
    status_t            res_status_reg, res_status_next;
    logic [OFF_W-1:0]   res_off_reg, res_off_next;
    logic [LOG_W-1:0]   res_log_reg, res_log_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [OFF_W-1:0]   out_off_reg, out_off_next;
    logic [LOG_W-1:0]   out_log_reg, out_log_next;

    // Free-list heads, one per level.
    logic [PTR_W-1:0]   head_reg [MAX_LOG+1];
    logic               hw_en;
    logic [LOG_W-1:0]   hw_idx;
    logic [PTR_W-1:0]   hw_data;
    logic [LOG_W-1:0]   hr_idx;
    logic [PTR_W-1:0]   head_rd;

    // Memory ports.
    logic               tag_we, next_we, prev_we;
    logic [OFF_W-1:0]   tag_waddr, next_waddr, prev_waddr;
    logic [TAG_W-1:0]   tag_wdata;
    logic [PTR_W-1:0]   next_wdata, prev_wdata;
    logic [OFF_W-1:0]   tag_raddr, next_raddr, prev_raddr;
    logic [TAG_W-1:0]   tag_rdata;
    logic [PTR_W-1:0]   next_rdata, prev_rdata;

    // Derived values.
    logic [UC_W-1:0]    ucnt_eff;
    logic [SHIFT_W-1:0] ub_eff;
    logic [OFF_W-1:0]   buddy;
    logic               buddy_oor;
    logic [LOG_W-1:0]   clg;
    logic [UC_W:0]      csz;
    logic               cfit;
    logic [LOG_W-1:0]   jn;
    logic [OFF_W-1:0]   split_off;
    logic               push_ret;

    bba_ram #(.WIDTH(TAG_W), .DEPTH(MAX_UNITS)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    bba_ram #(.WIDTH(PTR_W), .DEPTH(MAX_UNITS)) u_next_ram (
        .aclk  (aclk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    bba_ram #(.WIDTH(PTR_W), .DEPTH(MAX_UNITS)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    // Effective register values after clamping.
    assign ucnt_eff = (UC_W'(ucount_reg) > UC_MAX) ? UC_MAX : UC_W'(ucount_reg);
    assign ub_eff   = (ubytes_reg < UNIT_BYTES_MIN) ? SHIFT_W'(UNIT_BYTES_MIN)
                                                    : SHIFT_W'(ubytes_reg);

    // Buddy of the block being freed, and whether it lies outside the pool.
    assign buddy     = off_reg ^ (OFF_W'(1) << lg_reg);
    assign buddy_oor = (lg_reg >= LOG_TOP) || (32'(lg_reg) >= 32'(OFF_W)) ||
                       (UC_W'(buddy) >= ucnt_eff);

    // Carving step: does a block of the current level still fit?
    assign clg  = LOG_W'(carve_cnt_reg - 1'b1);
    assign csz  = (UC_W+1)'(1) << clg;
    assign cfit = (32'(clg) < 32'(UC_W)) && ((carve_off_reg + csz) <= {1'b0, ucnt_eff});

    // Split step: upper half of the current block one level down.
    assign jn        = j_reg - 1'b1;
    assign split_off = off_reg | (OFF_W'(1) << jn);

    assign head_rd = head_reg[hr_idx];

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_granted_offset = out_off_reg;
    assign m_granted_log    = out_log_reg;

    // Sequencer: next state, datapath updates and memory accesses.
    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        ubytes_next     = ubytes_reg;
        ucount_next     = ucount_reg;
        req_next        = req_reg;
        cur_next        = cur_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        lg_next         = lg_reg;
        off_next        = off_reg;
        buddy_next      = buddy_reg;
        push_off_next   = push_off_reg;
        push_lg_next    = push_lg_reg;
        h_next          = h_reg;
        clr_next        = clr_reg;
        carve_off_next  = carve_off_reg;
        carve_cnt_next  = carve_cnt_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_log_next    = res_log_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_off_next    = out_off_reg;
        out_log_next    = out_log_reg;
        hw_en           = 1'b0;
        hw_idx          = '0;
        hw_data         = NIL;
        hr_idx          = '0;
        tag_we          = 1'b0;
        tag_waddr       = '0;
        tag_wdata       = '0;
        next_we         = 1'b0;
        next_waddr      = '0;
        next_wdata      = NIL;
        prev_we         = 1'b0;
        prev_waddr      = '0;
        prev_wdata      = NIL;
        tag_raddr       = '0;
        next_raddr      = '0;
        prev_raddr      = '0;
        push_ret        = 1'b0;

        case (state_reg)
            // Clear every tag, one entry a cycle.
            ST_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next     = ST_CARVE;
                    carve_off_next = '0;
                    carve_cnt_next = CL_W'(MAX_LOG + 1);
                end
            end

            // Carve the pool from the largest level down.
            ST_CARVE: begin
                if (carve_cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    carve_cnt_next = carve_cnt_reg - 1'b1;
                    if (cfit) begin
                        push_off_next  = OFF_W'(carve_off_reg);
                        push_lg_next   = clg;
                        ret_next       = RET_CARVE;
                        carve_off_next = carve_off_reg + csz;
                        state_next     = ST_PUSH_A;
                    end
                end
            end

            ST_IDLE: begin
                tag_raddr = s_block_offset;
                if (s_valid) begin
                    if (s_operation == OP_FREE) begin
                        off_next = s_block_offset;
                        if (UC_W'(s_block_offset) >= ucnt_eff) begin
                            res_status_next = STAT_BAD_FREE;
                            res_off_next    = '0;
                            res_log_next    = '0;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_F_TAG;
                        end
                    end else begin
                        req_next = s_request_bytes;
                        cur_next = ub_eff;
                        i_next   = '0;
                        if (s_request_bytes == '0) begin
                            res_status_next = STAT_ZERO_SIZE;
                            res_off_next    = '0;
                            res_log_next    = '0;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_A_SIZE;
                        end
                    end
                end
            end

            // Find the smallest level whose block holds the request.
            ST_A_SIZE: begin
                if (cur_reg >= SHIFT_W'(req_reg)) begin
                    j_next     = i_reg;
                    state_next = ST_A_SEARCH;
                end else if (i_reg == LOG_TOP) begin
                    res_status_next = STAT_NO_SPACE;
                    res_off_next    = '0;
                    res_log_next    = '0;
                    state_next      = ST_DONE;
                end else begin
                    cur_next = cur_reg << 1;
                    i_next   = i_reg + 1'b1;
                end
            end

            // Find the first level with a free block.
            ST_A_SEARCH: begin
                hr_idx     = j_reg;
                next_raddr = head_rd[OFF_W-1:0];
                if (head_rd != NIL) begin
                    off_next   = head_rd[OFF_W-1:0];
                    state_next = ST_A_NEXT;
                end else if (j_reg == LOG_TOP) begin
                    res_status_next = STAT_NO_SPACE;
                    res_off_next    = '0;
                    res_log_next    = '0;
                    state_next      = ST_DONE;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end

            // Unlink the head block from its level.
            ST_A_NEXT: begin
                hw_en      = 1'b1;
                hw_idx     = j_reg;
                hw_data    = next_rdata;
                prev_we    = (next_rdata != NIL);
                prev_waddr = next_rdata[OFF_W-1:0];
                prev_wdata = NIL;
                state_next = ST_A_SPLIT;
            end

            // Split down, pushing each upper half onto its level.
            ST_A_SPLIT: begin
                if (j_reg > i_reg) begin
                    j_next        = jn;
                    push_off_next = split_off;
                    push_lg_next  = jn;
                    ret_next      = RET_SPLIT;
                    state_next    = ST_PUSH_A;
                end else begin
                    state_next = ST_A_MARK;
                end
            end

            ST_A_MARK: begin
                tag_we          = 1'b1;
                tag_waddr       = off_reg;
                tag_wdata       = tag_inuse(TAG_LOG_W'(i_reg));
                res_status_next = STAT_OK;
                res_off_next    = off_reg;
                res_log_next    = i_reg;
                state_next      = ST_DONE;
            end

            // Push a block onto the head of its level's free list.
            ST_PUSH_A: begin
                hr_idx     = push_lg_reg;
                next_we    = 1'b1;
                next_waddr = push_off_reg;
                next_wdata = head_rd;
                prev_we    = 1'b1;
                prev_waddr = push_off_reg;
                prev_wdata = NIL;
                tag_we     = 1'b1;
                tag_waddr  = push_off_reg;
                tag_wdata  = tag_free(TAG_LOG_W'(push_lg_reg));
                hw_en      = 1'b1;
                hw_idx     = push_lg_reg;
                hw_data    = PTR_W'(push_off_reg);
                h_next     = head_rd;
                if (head_rd != NIL) begin
                    state_next = ST_PUSH_B;
                end else begin
                    push_ret = 1'b1;
                end
            end

            ST_PUSH_B: begin
                prev_we    = 1'b1;
                prev_waddr = h_reg[OFF_W-1:0];
                prev_wdata = PTR_W'(push_off_reg);
                push_ret   = 1'b1;
            end

            // Check that the freed offset heads an allocated block.
            ST_F_TAG: begin
                if (!tag_rdata[TAG_INUSE_BIT]) begin
                    res_status_next = STAT_BAD_FREE;
                    res_off_next    = '0;
                    res_log_next    = '0;
                    state_next      = ST_DONE;
                end else begin
                    lg_next    = LOG_W'(tag_rdata[TAG_LOG_W-1:0]);
                    tag_we     = 1'b1;
                    tag_waddr  = off_reg;
                    state_next = ST_F_BUDDY;
                end
            end

            // Fetch the buddy's tag and links, or finish merging.
            ST_F_BUDDY: begin
                tag_raddr  = buddy;
                next_raddr = buddy;
                prev_raddr = buddy;
                buddy_next = buddy;
                if (buddy_oor) begin
                    push_off_next = off_reg;
                    push_lg_next  = lg_reg;
                    ret_next      = RET_FREE;
                    state_next    = ST_PUSH_A;
                end else begin
                    state_next = ST_F_BTAG;
                end
            end

            // Merge with a free buddy of the same level.
            ST_F_BTAG: begin
                if (tag_rdata != tag_free(TAG_LOG_W'(lg_reg))) begin
                    push_off_next = off_reg;
                    push_lg_next  = lg_reg;
                    ret_next      = RET_FREE;
                    state_next    = ST_PUSH_A;
                end else begin
                    if (prev_rdata == NIL) begin
                        hw_en   = 1'b1;
                        hw_idx  = lg_reg;
                        hw_data = next_rdata;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = prev_rdata[OFF_W-1:0];
                        next_wdata = next_rdata;
                    end
                    prev_we    = (next_rdata != NIL);
                    prev_waddr = next_rdata[OFF_W-1:0];
                    prev_wdata = prev_rdata;
                    tag_we     = 1'b1;
                    tag_waddr  = buddy_reg;
                    if (buddy_reg < off_reg) begin
                        off_next = buddy_reg;
                    end
                    lg_next    = lg_reg + 1'b1;
                    state_next = ST_F_BUDDY;
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_off_next    = res_off_reg;
                    out_log_next    = res_log_reg;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Return from a push to its caller.
        if (push_ret) begin
            case (ret_reg)
                RET_CARVE: begin
                    state_next = ST_CARVE;
                end
                RET_SPLIT: begin
                    state_next = ST_A_SPLIT;
                end
                RET_FREE: begin
                    res_status_next = STAT_OK;
                    res_off_next    = push_off_reg;
                    res_log_next    = push_lg_reg;
                    state_next      = ST_DONE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        // A configuration write rebuilds the pool.
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_UNIT_BYTES: ubytes_next = cfg_wdata[UB_W-1:0];
                CFG_UNIT_COUNT: ucount_next = cfg_wdata[CNT_W-1:0];
                default:        ubytes_next = ubytes_reg;
            endcase
            state_next = ST_CLEAR;
            clr_next   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= RET_CARVE;
            ubytes_reg    <= UNIT_BYTES_RST;
            ucount_reg    <= UNIT_COUNT_RST;
            clr_reg       <= '0;
            carve_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            ubytes_reg    <= ubytes_next;
            ucount_reg    <= ucount_next;
            clr_reg       <= clr_next;
            carve_cnt_reg <= carve_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        cur_reg        <= cur_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        lg_reg         <= lg_next;
        off_reg        <= off_next;
        buddy_reg      <= buddy_next;
        push_off_reg   <= push_off_next;
        push_lg_reg    <= push_lg_next;
        h_reg          <= h_next;
        carve_off_reg  <= carve_off_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_log_reg    <= res_log_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
        out_log_reg    <= out_log_next;
    end

    // Free-list heads: emptied on reset and on a configuration write.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            for (int k = 0; k <= MAX_LOG; k++) begin
                head_reg[k] <= NIL;
            end
        end else if (hw_en) begin
            head_reg[hw_idx] <= hw_data;
        end
    end

    // A configuration write always starts the rebuild, so no item is taken next cycle.
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready)
        else $error("input accepted right after a configuration write");

    // One item at a time: after an accepted beat the block is busy.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // A failed request reports zero offset and size.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_OK)) |->
        ((m_granted_offset == '0) && (m_granted_log == '0)))
        else $error("failed result carries a nonzero offset or size");

    // A granted or merged block is aligned to its own size.
    a_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_OK)) |->
        ((m_granted_offset & ((OFF_W'(1) << m_granted_log) - OFF_W'(1))) == '0))
        else $error("result block is not aligned to its size");

endmodule

`default_nettype wire

// ===== hdl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
